>>> hw/rtl/quote_aware_command_restyler_macros.svh
// Assertion helpers for the command restyler.
`ifndef QUOTE_AWARE_COMMAND_RESTYLER_MACROS_SVH
`define QUOTE_AWARE_COMMAND_RESTYLER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define QACR_ASSERT_IMPL(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("restyler check failed");

// Condition must never hold.
`define QACR_ASSERT_NEVER(lbl, cond) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("restyler check failed");

`endif

>>> hw/rtl/qacr_pkg.sv
package qacr_pkg;

	// Style codes
	localparam logic [1:0] STYLE_COMPACT  = 2'd0;
	localparam logic [1:0] STYLE_READABLE = 2'd1;
	localparam logic [1:0] STYLE_EXPANDED = 2'd2;

	// Register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_STYLE_MODE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_OP_SPACING   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PIPE_BREAK   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_INDENT_BYTE  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_INDENT_COUNT = 3'd4;

	// Characters
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// Queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [1:0] style_mode;
		logic       operator_spacing;
		logic       pipe_breaking;
		logic [7:0] indent_byte;
		logic [4:0] indent_count;
	} cfg_t;

	// One classified item: the beats it produces, in this order:
	// lead spaces, main byte, newline, indent run, trailing space, or an empty end marker.
	typedef struct packed {
		logic [1:0] lead;
		logic       has_main;
		logic [7:0] main_byte;
		logic       nl;
		logic       trail;
		logic       empty;
		logic       last;
	} plan_t;

	function automatic logic is_ws(input logic [7:0] b);
		is_ws = (b == CH_SPACE) || (b inside {[8'd9:8'd13]});
	endfunction

	function automatic logic is_op(input logic [7:0] b);
		is_op = (b == CH_PIPE) || (b == CH_AMP) || (b == CH_SEMI);
	endfunction

endpackage

>>> hw/rtl/qacr_front.sv
module qacr_front
	import qacr_pkg::*;
#(
	parameter int MAX_INDENT = 16,
	parameter int IND_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             accept,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output logic             push,
	output plan_t            plan,
	output logic [IND_W-1:0] plan_ind
);

	localparam int CW = (IND_W > 5) ? IND_W : 5;

	logic       inside_quote_q, quote_dbl_q, prior_ws_q, emitted_q, held_q;
	logic [7:0] prior_char_q;

	logic       inside_quote_n, quote_dbl_n, prior_ws_n, emitted_n, held_n;
	logic [7:0] prior_char_n;

	logic             compact, expanded, flush0, emitted1, spaced, any_beat;
	logic [7:0]       prior1;
	logic [CW-1:0]    cnt_ext;
	logic [IND_W-1:0] ind_sat;

	// Indent run length, saturated
	always_comb begin
		cnt_ext = CW'(cfg.indent_count);
		if (cnt_ext > CW'(MAX_INDENT)) begin
			ind_sat = IND_W'(MAX_INDENT);
		end else begin
			ind_sat = IND_W'(cnt_ext);
		end
	end

	// Classify one byte and work out the next command state
	always_comb begin
		compact  = cfg.style_mode == STYLE_COMPACT;
		expanded = cfg.style_mode == STYLE_EXPANDED;
		flush0   = !compact && held_q;
		emitted1 = emitted_q | flush0;
		prior1   = flush0 ? CH_SPACE : prior_char_q;
		spaced   = cfg.operator_spacing && is_op(in_byte);

		inside_quote_n = inside_quote_q;
		quote_dbl_n    = quote_dbl_q;
		if (!inside_quote_q && (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE)) begin
			inside_quote_n = 1'b1;
			quote_dbl_n    = in_byte == CH_DQUOTE;
		end else if (inside_quote_q &&
			in_byte == (quote_dbl_q ? CH_DQUOTE : CH_SQUOTE)) begin
			inside_quote_n = 1'b0;
		end

		plan           = '0;
		plan.lead      = {1'b0, flush0};
		plan.main_byte = in_byte;
		plan.last      = in_last;
		plan_ind       = '0;
		held_n         = 1'b0;
		prior_ws_n     = prior_ws_q;

		if (compact) begin
			held_n = held_q;
			if (inside_quote_n) begin
				plan.lead     = {1'b0, held_q};
				plan.has_main = 1'b1;
				held_n        = 1'b0;
				prior_ws_n    = 1'b0;
			end else if (in_byte == CH_NL) begin
				plan.has_main = 1'b1;
				held_n        = 1'b0;
				prior_ws_n    = 1'b0;
			end else if (is_ws(in_byte)) begin
				if (!prior_ws_q && emitted_q) begin
					held_n     = 1'b1;
					prior_ws_n = 1'b1;
				end
			end else begin
				plan.lead     = {1'b0, held_q};
				plan.has_main = 1'b1;
				held_n        = 1'b0;
				prior_ws_n    = 1'b0;
			end
		end else if (expanded) begin
			prior_ws_n    = 1'b0;
			plan.has_main = 1'b1;
			if (!inside_quote_n && in_byte == CH_PIPE && cfg.pipe_breaking) begin
				plan.lead = flush0 ? 2'd2 : 2'd1;
				plan.nl   = 1'b1;
				plan_ind  = ind_sat;
			end
		end else begin
			if (inside_quote_n) begin
				plan.has_main = 1'b1;
				prior_ws_n    = 1'b0;
			end else if (is_ws(in_byte)) begin
				if (in_byte == CH_NL || !prior_ws_q) begin
					plan.has_main = 1'b1;
					prior_ws_n    = in_byte != CH_NL;
				end
			end else begin
				if (spaced && emitted1 && !is_ws(prior1)) begin
					plan.lead = 2'd1;
				end
				plan.has_main = 1'b1;
				prior_ws_n    = spaced;
				plan.trail    = spaced;
			end
		end

		// End of command: a held space goes out last
		if (in_last && held_n) begin
			plan.trail = 1'b1;
			held_n     = 1'b0;
		end

		any_beat = (plan.lead != 2'd0) || plan.has_main || plan.nl ||
			(plan_ind != '0) || plan.trail;
		plan.empty = in_last && !any_beat;

		if (plan.trail) begin
			prior_char_n = CH_SPACE;
		end else if (plan_ind != '0) begin
			prior_char_n = cfg.indent_byte;
		end else if (plan.nl) begin
			prior_char_n = CH_NL;
		end else if (plan.has_main) begin
			prior_char_n = in_byte;
		end else if (plan.lead != 2'd0) begin
			prior_char_n = CH_SPACE;
		end else begin
			prior_char_n = prior_char_q;
		end
		emitted_n = emitted_q | any_beat;

		if (in_last) begin
			inside_quote_n = 1'b0;
			quote_dbl_n    = 1'b0;
			prior_ws_n     = 1'b0;
			emitted_n      = 1'b0;
			prior_char_n   = '0;
			held_n         = 1'b0;
		end

		push = accept && (any_beat || plan.empty);
	end

	// Command state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_quote_q <= 1'b0;
			quote_dbl_q    <= 1'b0;
			prior_ws_q     <= 1'b0;
			emitted_q      <= 1'b0;
			held_q         <= 1'b0;
			prior_char_q   <= '0;
		end else if (accept) begin
			inside_quote_q <= inside_quote_n;
			quote_dbl_q    <= quote_dbl_n;
			prior_ws_q     <= prior_ws_n;
			emitted_q      <= emitted_n;
			held_q         <= held_n;
			prior_char_q   <= prior_char_n;
		end
	end

endmodule

>>> hw/rtl/qacr_queue.sv
module qacr_queue
	import qacr_pkg::*;
#(
	parameter int IND_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  plan_t              push_plan,
	input  logic [IND_W-1:0]   push_ind,
	input  logic               pop,
	output plan_t              head_plan,
	output logic [IND_W-1:0]   head_ind,
	output logic               full,
	output logic               nempty,
	output logic [Q_CNT_W-1:0] count
);

	plan_t            plan_mem [Q_DEPTH];
	logic [IND_W-1:0] ind_mem  [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full      = count_q == Q_CNT_W'(Q_DEPTH);
	assign nempty    = count_q != '0;
	assign count     = count_q;
	assign head_plan = plan_mem[rd_ptr_q];
	assign head_ind  = ind_mem[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			plan_mem[wr_ptr_q] <= push_plan;
			ind_mem[wr_ptr_q]  <= push_ind;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/qacr_back.sv
module qacr_back
	import qacr_pkg::*;
#(
	parameter int IND_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       indent_byte,
	input  plan_t            head_plan,
	input  logic [IND_W-1:0] head_ind,
	input  logic             q_nempty,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic             out_has_byte,
	output logic             out_end
);

	plan_t            cur_q, nxt;
	logic [IND_W-1:0] ind_q, ind_nxt;
	logic             valid_q, beat, more, load;

	// Current beat and what is left after it
	always_comb begin
		nxt          = cur_q;
		ind_nxt      = ind_q;
		out_has_byte = 1'b1;
		if (cur_q.lead != 2'd0) begin
			out_byte = CH_SPACE;
			nxt.lead = cur_q.lead - 2'd1;
		end else if (cur_q.has_main) begin
			out_byte     = cur_q.main_byte;
			nxt.has_main = 1'b0;
		end else if (cur_q.nl) begin
			out_byte = CH_NL;
			nxt.nl   = 1'b0;
		end else if (ind_q != '0) begin
			out_byte = indent_byte;
			ind_nxt  = ind_q - 1'b1;
		end else if (cur_q.trail) begin
			out_byte  = CH_SPACE;
			nxt.trail = 1'b0;
		end else begin
			out_byte     = '0;
			out_has_byte = 1'b0;
			nxt.empty    = 1'b0;
		end
		more = (nxt.lead != 2'd0) || nxt.has_main || nxt.nl || (ind_nxt != '0) ||
			nxt.trail || nxt.empty;
	end

	assign out_valid = valid_q;
	assign out_end   = cur_q.last && !more;
	assign beat      = valid_q && !out_stall;
	assign load      = !valid_q || (beat && !more);
	assign q_pop     = load && q_nempty;

	// Plan register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= head_plan;
			ind_q <= head_ind;
		end else if (beat) begin
			cur_q <= nxt;
			ind_q <= ind_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= q_nempty;
		end
	end

endmodule

>>> hw/rtl/quote_aware_command_restyler.sv
// Path: an input beat's plan is written into the plan queue, then loaded into the output
// sequencer's plan register, from which its result beats are offered.
// Rate: one input beat per cycle while each yields at most one result beat and out_stall
// is low; an item holds the output sequencer until its last result beat is taken, and
// input stalls once the two-entry plan queue is full.
// Reset: arst_n clears the command state and queue and loads register defaults.
`include "quote_aware_command_restyler_macros.svh"

module quote_aware_command_restyler
	import qacr_pkg::*;
#(
	parameter int MAX_INDENT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [7:0]           wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 out_has_byte,
	output logic                 out_end
);

	localparam int IND_W = $clog2(MAX_INDENT + 1);

	cfg_t               cfg_q;
	logic               accept, push, pop, q_full, q_nempty;
	plan_t              push_plan, head_plan;
	logic [IND_W-1:0]   push_ind, head_ind;
	logic [Q_CNT_W-1:0] q_count;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.style_mode       <= STYLE_READABLE;
			cfg_q.operator_spacing <= 1'b1;
			cfg_q.pipe_breaking    <= 1'b0;
			cfg_q.indent_byte      <= CH_SPACE;
			cfg_q.indent_count     <= 5'd2;
		end else if (wr_en) begin
			case (wr_index)
				REG_STYLE_MODE:   cfg_q.style_mode       <= wr_data[1:0];
				REG_OP_SPACING:   cfg_q.operator_spacing <= wr_data[0];
				REG_PIPE_BREAK:   cfg_q.pipe_breaking    <= wr_data[0];
				REG_INDENT_BYTE:  cfg_q.indent_byte      <= wr_data;
				REG_INDENT_COUNT: cfg_q.indent_count     <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	qacr_front #(
		.MAX_INDENT(MAX_INDENT),
		.IND_W(IND_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.accept(accept),
		.in_byte(in_byte),
		.in_last(in_last),
		.push(push),
		.plan(push_plan),
		.plan_ind(push_ind)
	);

	qacr_queue #(
		.IND_W(IND_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_plan(push_plan),
		.push_ind(push_ind),
		.pop(pop),
		.head_plan(head_plan),
		.head_ind(head_ind),
		.full(q_full),
		.nempty(q_nempty),
		.count(q_count)
	);

	qacr_back #(
		.IND_W(IND_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.indent_byte(cfg_q.indent_byte),
		.head_plan(head_plan),
		.head_ind(head_ind),
		.q_nempty(q_nempty),
		.q_pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.out_has_byte(out_has_byte),
		.out_end(out_end)
	);

	// Checks
	`QACR_ASSERT_IMPL(a_empty_is_end, out_valid && !out_has_byte, out_end && out_byte == 8'd0)
	`QACR_ASSERT_NEVER(a_no_overflow, push && q_full)
	`QACR_ASSERT_NEVER(a_no_underflow, pop && q_count == '0)

endmodule
